// ----- hw/rtl/rne_pkg.sv -----
// Shared types, constants and the decimal digit split for the Roman numeral encoder.
// Depends on nothing; every other file of the block imports it.
package rne_pkg;

   localparam int unsigned VALUE_W = 12;

   localparam logic [VALUE_W-1:0] ROMAN_MAX     = 12'd3999;
   localparam logic [VALUE_W-1:0] UNIT_THOUSAND = 12'd1000;
   localparam logic [VALUE_W-1:0] UNIT_HUNDRED  = 12'd100;
   localparam logic [VALUE_W-1:0] UNIT_TEN      = 12'd10;

   typedef enum logic [2:0] {
      SYM_I = 3'd0,
      SYM_V = 3'd1,
      SYM_X = 3'd2,
      SYM_L = 3'd3,
      SYM_C = 3'd4,
      SYM_D = 3'd5,
      SYM_M = 3'd6
   } sym_type;

   // One classified item as it sits in the queue between front and back.
   typedef struct packed {
      logic       oor;
      logic [1:0] thou;
      logic [3:0] hund;
      logic [3:0] tens;
      logic [3:0] units;
   } digits_type;

   typedef struct packed {
      logic [3:0]         q;
      logic [VALUE_W-1:0] r;
   } split_type;

   // Quotient digit (capped at 9) and remainder of x by a constant unit,
   // found with nine independent compares against the unit multiples.
   function automatic split_type split_digit(input logic [VALUE_W-1:0] x,
                                             input logic [VALUE_W-1:0] unit);
      split_type          res;
      logic [VALUE_W+1:0] step;
      res.q = '0;
      res.r = x;
      step  = '0;
      for (int k = 1; k <= 9; k++) begin
         step = step + {2'b00, unit};
         if ({2'b00, x} >= step) begin
            res.q = 4'(k);
            res.r = x - step[VALUE_W-1:0];
         end
      end
      return res;
   endfunction

endpackage

// ----- hw/rtl/rne_front.sv -----
// Front of the Roman numeral encoder: accepts items, checks range, splits into digits.
// Depends on rne_pkg; feeds rne_queue.
module rne_front
   import rne_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [VALUE_W-1:0] req_value,
   output logic               push_valid,
   input  logic               push_ready,
   output digits_type         push_data
);

   logic       s1_valid_ff, s1_valid_in;
   logic       s1_oor_ff;
   logic [1:0] s1_thou_ff;
   logic [9:0] s1_rem_ff;

   logic       s2_valid_ff, s2_valid_in;
   logic       s2_oor_ff;
   logic [1:0] s2_thou_ff;
   logic [3:0] s2_hund_ff;
   logic [6:0] s2_rem_ff;

   logic      adv, s1_en;
   split_type th_split, hu_split, te_split;

   assign adv       = !s2_valid_ff || push_ready;
   assign s1_en     = adv || !s1_valid_ff;
   assign req_ready = s1_en;

   assign s1_valid_in = req_valid;
   assign s2_valid_in = s1_valid_ff;

   always_comb begin
      th_split = split_digit(req_value, UNIT_THOUSAND);
      hu_split = split_digit({2'b00, s1_rem_ff}, UNIT_HUNDRED);
      te_split = split_digit({5'b00000, s2_rem_ff}, UNIT_TEN);
   end

   // Tens and units come straight off the last stage into the queue.
   assign push_valid      = s2_valid_ff;
   assign push_data.oor   = s2_oor_ff;
   assign push_data.thou  = s2_thou_ff;
   assign push_data.hund  = s2_hund_ff;
   assign push_data.tens  = te_split.q;
   assign push_data.units = te_split.r[3:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_en) s1_valid_ff <= s1_valid_in;
         if (adv)   s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_oor_ff  <= (req_value == '0) || (req_value > ROMAN_MAX);
         s1_thou_ff <= th_split.q[1:0];
         s1_rem_ff  <= th_split.r[9:0];
      end
      if (adv) begin
         s2_oor_ff  <= s1_oor_ff;
         s2_thou_ff <= s1_thou_ff;
         s2_hund_ff <= hu_split.q;
         s2_rem_ff  <= hu_split.r[6:0];
      end
   end

endmodule

// ----- hw/rtl/rne_queue.sv -----
// Short queue of classified items between the front and the back.
// Depends on rne_pkg for the entry type.
module rne_queue
   import rne_pkg::*;
#(
   parameter int unsigned DEPTH = 2
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push_valid,
   output logic       push_ready,
   input  digits_type push_data,
   output logic       head_valid,
   input  logic       pop,
   output digits_type head_data
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   digits_type       mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = count_ff != CNT_W'(DEPTH);
   assign head_valid = count_ff != '0;
   assign head_data  = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_data;
   end

endmodule

// ----- hw/rtl/rne_back.sv -----
// Back of the Roman numeral encoder: walks the queue head digit by digit, one symbol a cycle
// unless rsp stalls. Depends on rne_pkg; reads rne_queue and drives the result register.
module rne_back
   import rne_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       head_valid,
   input  digits_type head_data,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_symbol,
   output logic       rsp_out_of_range,
   output logic       rsp_last
);

   function automatic logic [3:0] digit_of(input digits_type h, input logic [1:0] idx);
      logic [3:0] d;
      unique case (idx)
         2'd3:    d = {2'b00, h.thou};
         2'd2:    d = h.hund;
         2'd1:    d = h.tens;
         default: d = h.units;
      endcase
      return d;
   endfunction

   function automatic logic [2:0] len_of(input logic [3:0] d);
      logic [2:0] n;
      unique case (d) inside
         [4'd0:4'd3]: n = d[2:0];
         4'd4, 4'd9:  n = 3'd2;
         [4'd5:4'd8]: n = 3'(d - 4'd4);
         default:     n = 3'd0;
      endcase
      return n;
   endfunction

   function automatic sym_type sym_of(input logic [1:0] idx, input logic [3:0] d,
                                      input logic [1:0] pos);
      sym_type one, five, ten, s;
      unique case (idx)
         2'd3:    begin one = SYM_M; five = SYM_M; ten = SYM_M; end
         2'd2:    begin one = SYM_C; five = SYM_D; ten = SYM_M; end
         2'd1:    begin one = SYM_X; five = SYM_L; ten = SYM_C; end
         default: begin one = SYM_I; five = SYM_V; ten = SYM_X; end
      endcase
      unique case (d) inside
         4'd4:        s = (pos == 2'd0) ? one : five;
         4'd9:        s = (pos == 2'd0) ? one : ten;
         [4'd5:4'd8]: s = (pos == 2'd0) ? five : one;
         default:     s = one;
      endcase
      return s;
   endfunction

   logic       started_ff, started_in;
   logic [1:0] idx_ff, idx_in;
   logic [1:0] pos_ff, pos_in;

   logic       rsp_valid_ff, rsp_valid_in;
   sym_type    sym_ff, sym_in;
   logic       oor_ff, oor_in;
   logic       last_ff, last_in;

   logic [3:0] nz;
   logic [1:0] first_idx, lower_idx, eff_idx, eff_pos;
   logic       lower_found, out_adv, emit, at_end;
   logic [3:0] cur_d;
   logic [2:0] cur_len;

   assign out_adv = !rsp_valid_ff || rsp_ready;
   assign emit    = head_valid && out_adv;

   always_comb begin
      nz = {head_data.thou != '0, head_data.hund != '0,
            head_data.tens != '0, head_data.units != '0};
      first_idx = '0;
      for (int k = 0; k < 4; k++) begin
         if (nz[k]) first_idx = 2'(k);
      end
      eff_idx = started_ff ? idx_ff : first_idx;
      eff_pos = started_ff ? pos_ff : 2'd0;
      lower_found = 1'b0;
      lower_idx   = '0;
      for (int k = 0; k < 4; k++) begin
         if (2'(k) < eff_idx && nz[k]) begin
            lower_found = 1'b1;
            lower_idx   = 2'(k);
         end
      end
      cur_d   = digit_of(head_data, eff_idx);
      cur_len = len_of(cur_d);
      at_end  = ({1'b0, eff_pos} + 3'd1) == cur_len;
   end

   always_comb begin
      started_in   = started_ff;
      idx_in       = idx_ff;
      pos_in       = pos_ff;
      pop          = 1'b0;
      rsp_valid_in = emit;
      sym_in       = SYM_I;
      oor_in       = 1'b0;
      last_in      = 1'b0;
      if (emit) begin
         if (head_data.oor) begin
            oor_in     = 1'b1;
            last_in    = 1'b1;
            pop        = 1'b1;
            started_in = 1'b0;
         end else begin
            sym_in = sym_of(eff_idx, cur_d, eff_pos);
            if (at_end && !lower_found) begin
               last_in    = 1'b1;
               pop        = 1'b1;
               started_in = 1'b0;
            end else if (at_end) begin
               idx_in     = lower_idx;
               pos_in     = 2'd0;
               started_in = 1'b1;
            end else begin
               idx_in     = eff_idx;
               pos_in     = eff_pos + 2'd1;
               started_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff   <= 1'b0;
         idx_ff       <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         started_ff <= started_in;
         idx_ff     <= idx_in;
         pos_ff     <= pos_in;
         if (out_adv) rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_adv) begin
         sym_ff  <= sym_in;
         oor_ff  <= oor_in;
         last_ff <= last_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_symbol       = sym_ff;
   assign rsp_out_of_range = oor_ff;
   assign rsp_last         = last_ff;

endmodule

// ----- hw/rtl/roman_numeral_encoder.sv -----
// Top level of the Roman numeral encoder: front, queue and back wired together.
// Depends on rne_pkg, rne_front, rne_queue and rne_back.
//
//   channel | ports                                        | moves
//   --------+----------------------------------------------+-------------------------------
//   req     | req_valid, req_ready, req_value[11:0]        | one number per item
//   rsp     | rsp_valid, rsp_ready, rsp_symbol[2:0],       | one symbol per item, last set
//           | rsp_out_of_range, rsp_last                   | on the final one of a number
//
// An accepted number passes the two front pipeline stages (thousands split, then hundreds),
// enters the queue with its tens and units, and then yields one result item per cycle, unless
// rsp stalls, from the back sequencer: a number gives 1 to 15 result items, as many as it has
// symbols, since the single result register moves one symbol per cycle while rsp is not stalled.
// Reset clears the pipeline valids, the queue pointers, the sequencer and the result valid.
// A stall on rsp holds the back only; the front keeps accepting until QUEUE_DEPTH items wait
// in the queue and both front stages are full.
module roman_numeral_encoder
   import rne_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [VALUE_W-1:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_symbol,
   output logic               rsp_out_of_range,
   output logic               rsp_last
);

   logic       push_valid, push_ready;
   digits_type push_data;
   logic       head_valid, q_pop;
   digits_type head_data;

   // Accept, range check and digit split.
   rne_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_value  (req_value),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   // Hold classified items so the front and back stall on their own.
   rne_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .head_valid (head_valid),
      .pop        (q_pop),
      .head_data  (head_data)
   );

   // Advance through the digits of the head item, one symbol per cycle unless rsp stalls.
   rne_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (head_valid),
      .head_data        (head_data),
      .pop              (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_symbol       (rsp_symbol),
      .rsp_out_of_range (rsp_out_of_range),
      .rsp_last         (rsp_last)
   );

   // Dropping the head item must coincide with loading its final symbol.
   a_pop_loads_last : assert property (@(posedge clock) disable iff (reset)
      q_pop |=> rsp_valid && rsp_last)
      else $error("queue head dropped without a last result");

   // An error result is a single item with symbol zero.
   a_error_single : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_of_range |-> rsp_last && rsp_symbol == 3'(SYM_I))
      else $error("error result is not a lone last item");

   // Only the queue head is ever dropped.
   a_pop_has_head : assert property (@(posedge clock) disable iff (reset)
      q_pop |-> head_valid)
      else $error("pop from an empty queue");

   // A valid run never carries the unused symbol code.
   a_symbol_code : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_symbol != 3'd7)
      else $error("symbol code out of range");

endmodule

// ----- verif/roman_numeral_encoder_check.sv -----
// Result checker for the Roman numeral encoder: watches the req and rsp channels,
// expands every accepted number into its symbol run and compares each result item.
// Depends on rne_pkg for the value width, the range limit and the symbol codes.
module roman_numeral_encoder_check
   import rne_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [VALUE_W-1:0] req_value,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [2:0]         rsp_symbol,
   input  logic               rsp_out_of_range,
   input  logic               rsp_last,
   output int                 fail_count,
   output int                 open_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      sym_type symbol;
      logic    oor;
      logic    last;
   } roman_item_type;

   roman_item_type pending_symbols [$];

   initial fail_count = 0;
   initial open_count = 0;

   task automatic report_mismatch(input string msg);
      $display("%0t ns rsp mismatch: %s", $time, msg);
      fail_count++;
   endtask

   // Append the symbol run of one number, most significant first; out-of-range
   // numbers give a single error item.
   function automatic void expand_numeral(input logic [VALUE_W-1:0] value);
      int             n, d, p, k;
      int             place [3];
      sym_type        one [3];
      sym_type        five [3];
      sym_type        ten [3];
      sym_type        run [$];
      roman_item_type item;
      if (value == '0 || value > ROMAN_MAX) begin
         item.symbol = SYM_I;
         item.oor    = 1'b1;
         item.last   = 1'b1;
         pending_symbols.push_back(item);
         return;
      end
      n = int'(value);
      one  = '{SYM_C, SYM_X, SYM_I};
      five = '{SYM_D, SYM_L, SYM_V};
      ten  = '{SYM_M, SYM_C, SYM_X};
      place = '{(n % 1000) / 100, (n % 100) / 10, n % 10};
      for (k = 0; k < n / 1000; k++) run.push_back(SYM_M);
      for (p = 0; p < 3; p++) begin
         d = place[p];
         if (d == 9) begin
            run.push_back(one[p]);
            run.push_back(ten[p]);
         end else if (d == 4) begin
            run.push_back(one[p]);
            run.push_back(five[p]);
         end else begin
            if (d >= 5) begin
               run.push_back(five[p]);
               d = d - 5;
            end
            for (k = 0; k < d; k++) run.push_back(one[p]);
         end
      end
      foreach (run[i]) begin
         item.symbol = run[i];
         item.oor    = 1'b0;
         item.last   = (i == run.size() - 1);
         pending_symbols.push_back(item);
      end
   endfunction

   always @(posedge clock) begin
      roman_item_type want;
      if (reset) begin
         pending_symbols.delete();
      end else begin
         if (req_valid && req_ready) expand_numeral(req_value);
         if (rsp_valid && rsp_ready) begin
            if (pending_symbols.size() == 0) begin
               report_mismatch($sformatf("unexpected item symbol %0d oor %0b last %0b",
                                         rsp_symbol, rsp_out_of_range, rsp_last));
            end else begin
               want = pending_symbols.pop_front();
               if (rsp_symbol !== want.symbol)
                  report_mismatch($sformatf("symbol %0d, want %0d",
                                            rsp_symbol, want.symbol));
               if (rsp_out_of_range !== want.oor)
                  report_mismatch($sformatf("out_of_range %0b, want %0b",
                                            rsp_out_of_range, want.oor));
               if (rsp_last !== want.last)
                  report_mismatch($sformatf("last %0b, want %0b", rsp_last, want.last));
            end
         end
      end
      open_count <= pending_symbols.size();
   end

endmodule

// ----- verif/roman_numeral_encoder_test.sv -----
// Top of the Roman numeral encoder testbench: clock, reset, number stimulus, rsp
// back-pressure, watchdog and verdict. Depends on rne_pkg, roman_numeral_encoder
// and roman_numeral_encoder_check.
module roman_numeral_encoder_test;
   import rne_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RESET_CYCLES    = 11;
   localparam int RSP_HOLD_CYCLES = 300;   // long receiver hold-off, fills the queue
   localparam int QUIET_LIMIT     = 3000;  // cycles with no item moving on either side
   localparam int DRAIN_CYCLES    = 40;    // settle time after the last expected item

   logic               clock;
   logic               reset     = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [VALUE_W-1:0] req_value = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [2:0]         rsp_symbol;
   logic               rsp_out_of_range;
   logic               rsp_last;

   int fail_count;
   int open_count;

   // Knobs shared by the sender and the receiver process.
   bit req_gaps_on  = 1'b1;
   bit rsp_gaps_on  = 1'b1;
   bit rsp_hold_req = 1'b0;

   roman_numeral_encoder dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_symbol      (rsp_symbol),
      .rsp_out_of_range(rsp_out_of_range),
      .rsp_last        (rsp_last)
   );

   roman_numeral_encoder_check checker_inst (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_symbol      (rsp_symbol),
      .rsp_out_of_range(rsp_out_of_range),
      .rsp_last        (rsp_last),
      .fail_count      (fail_count),
      .open_count      (open_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Idle length: mostly none or short, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Mostly legal numbers, with zero and the values above the range mixed in.
   function automatic logic [VALUE_W-1:0] random_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 85) return VALUE_W'($urandom_range(1, 3999));
      if (r < 95) return VALUE_W'($urandom_range(4000, 4095));
      return '0;
   endfunction

   // Call right after a rising edge. Hold valid and value until the item is taken;
   // leave valid high so the next item can follow without a bubble.
   task automatic offer_value(input logic [VALUE_W-1:0] value);
      int gap;
      gap = req_gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= value;
      do @(posedge clock); while (!req_ready);
   endtask

   // Drop valid and wait until every predicted symbol has come out.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (open_count != 0);
   endtask

   // Receiver: random ready pattern, plus one long hold-off on request from the sender.
   initial begin
      int run_len;
      int stall_len;
      @(posedge clock);
      forever begin
         if (rsp_hold_req) begin
            rsp_ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
            rsp_hold_req = 1'b0;
         end
         rsp_ready <= 1'b1;
         run_len = $urandom_range(1, 6);
         repeat (run_len) @(posedge clock);
         stall_len = rsp_gaps_on ? pick_gap() : 0;
         if (stall_len > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall_len) @(posedge clock);
         end
      end
   end

   // Watchdog: end the run if no item moves on either channel for too long.
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      logic [VALUE_W-1:0] corner [$];
      // Range edges, all-ones and all-zeros, the longest run, every subtractive
      // form, each single symbol, and the top bit alone.
      corner = '{12'd0, 12'd1, 12'd3999, 12'd4000, 12'd4095, 12'd3888,
                 12'd4, 12'd9, 12'd40, 12'd90, 12'd400, 12'd900,
                 12'd5, 12'd10, 12'd50, 12'd100, 12'd500, 12'd1000,
                 12'd2048, 12'd1994, 12'd444, 12'd999, 12'd3, 12'd8};

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (corner[i]) offer_value(corner[i]);

      // Random numbers with idling on both sides.
      repeat (20) offer_value(random_value());

      // Hold off the receiver while numbers with long runs keep coming back to
      // back, so the queue fills and req_ready drops; then pause until drained.
      req_gaps_on  = 1'b0;
      rsp_hold_req = 1'b1;
      repeat (12) offer_value(VALUE_W'($urandom_range(2000, 3999)));
      wait_drained();

      // A stretch at full speed on both sides.
      rsp_gaps_on = 1'b0;
      repeat (20) offer_value(random_value());

      // Back to random idling everywhere.
      req_gaps_on = 1'b1;
      rsp_gaps_on = 1'b1;
      repeat (20) offer_value(random_value());

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && open_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
